/* rtl/core/fbci_pkg.sv */
// Shared constants, types and helper functions of the fault blink code indicator.
package fbci_pkg;

  // Widths of the configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_GAP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_GAP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TENS_TONE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ONES_TONE   = 3'd5;

  // Register reset values.
  localparam logic [7:0]  TICK_PERIOD_RST = 8'd10;
  localparam logic [15:0] PULSE_RST       = 16'd100;
  localparam logic [15:0] GROUP_GAP_RST   = 16'd350;
  localparam logic [15:0] REPEAT_GAP_RST  = 16'd1000;
  localparam logic [11:0] TENS_TONE_RST   = 12'd1500;
  localparam logic [11:0] ONES_TONE_RST   = 12'd2400;

  // Boot melody length and the width of its note counter.
  localparam int unsigned MELODY_NOTES = 5;
  localparam int unsigned MEL_IDX_W    = $clog2(MELODY_NOTES + 1);

  // Pulse sequencer stages.
  localparam logic [1:0] STG_IDLE       = 2'd0;
  localparam logic [1:0] STG_PULSING    = 2'd1;
  localparam logic [1:0] STG_GROUP_GAP  = 2'd2;
  localparam logic [1:0] STG_REPEAT_GAP = 2'd3;

  // Time stamps and deadlines.
  typedef logic [31:0] ms_t;

  // Note frequency of a melody entry; zero is a rest.
  function automatic logic [11:0] melody_hz(input logic [2:0] idx);
    logic [11:0] hz;
    case (idx)
      3'd0:    hz = 12'd900;
      3'd2:    hz = 12'd1350;
      3'd4:    hz = 12'd1900;
      default: hz = 12'd0;
    endcase
    return hz;
  endfunction

  // Duration of a melody entry in milliseconds.
  function automatic logic [7:0] melody_ms(input logic [2:0] idx);
    logic [7:0] ms;
    case (idx)
      3'd0, 3'd2: ms = 8'd90;
      3'd4:       ms = 8'd140;
      default:    ms = 8'd50;
    endcase
    return ms;
  endfunction

  // A deadline is reached once the wrapped difference is non-negative.
  function automatic logic reached(input ms_t now, input ms_t deadline);
    ms_t diff;
    diff = now - deadline;
    return ~diff[31];
  endfunction

  // A zero digit is shown as ten pulses.
  function automatic logic [3:0] digit_pulses(input logic [3:0] d);
    return (d == 4'd0) ? 4'd10 : d;
  endfunction

endpackage

/* rtl/core/fault_blink_code_indicator.sv */
// Fault blink code indicator: one status word in, one LED and buzzer word out.
// The result word for an input word is registered and presented in the cycle after it is accepted.
// Throughput: one word per cycle; the output register is reloaded whenever it is empty
// or being taken in the same cycle, so ready only drops while a result waits.
// Reset (rst_n low, synchronous): all state clears and registers return to their defaults.
module fault_blink_code_indicator (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [fbci_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbci_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_fault_active,
  input  logic [6:0]                      in_fault_code,
  input  logic                            in_left_detecting,
  input  logic                            in_right_detecting,
  input  logic                            in_left_running,
  input  logic                            in_right_running,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_led_on,
  output logic                            out_tone_on,
  output logic [11:0]                     out_tone_hz
);

  // Configuration registers
  logic [7:0]  tick_period_r;
  logic [15:0] pulse_ms_r, group_gap_r, repeat_gap_r;
  logic [11:0] tens_tone_r, ones_tone_r;

  // Sequencer state
  fbci_pkg::ms_t time_now_r, time_now_nxt;
  fbci_pkg::ms_t mel_deadline_r, mel_deadline_nxt;
  fbci_pkg::ms_t pulse_deadline_r, pulse_deadline_nxt;
  logic [3:0] idle_phase_r, idle_phase_nxt;
  logic [3:0] idle_div_r, idle_div_nxt;
  logic [fbci_pkg::MEL_IDX_W-1:0] mel_idx_r, mel_idx_nxt;
  logic mel_done_r, mel_done_nxt;
  logic ann_valid_r, ann_valid_nxt;
  logic [6:0] ann_code_r, ann_code_nxt;
  logic [3:0] tens_r, tens_nxt, ones_r, ones_nxt;
  logic group_r, group_nxt;
  logic [3:0] pulses_left_r, pulses_left_nxt;
  logic [1:0] stage_r, stage_nxt;
  logic pulse_on_r, pulse_on_nxt;
  logic led_r, led_nxt;
  logic tone_act_r, tone_act_nxt;
  logic [11:0] tone_hz_r, tone_hz_nxt;
  logic out_valid_r;

  logic        in_fire;
  logic        detecting, running;
  logic [14:0] code_mul;
  logic [3:0]  code_tens;
  logic [6:0]  code_tens_x10;
  logic [3:0]  code_ones;
  logic [2:0]  mel_sel;

  // Accept a word whenever the output register is free or draining.
  assign in_ready  = ~out_valid_r | out_ready;
  assign in_fire   = in_valid & in_ready;
  assign out_valid = out_valid_r;

  assign out_led_on  = led_r;
  assign out_tone_on = tone_act_r;
  assign out_tone_hz = tone_hz_r;

  assign detecting = in_left_detecting | in_right_detecting;
  assign running   = in_left_running | in_right_running;

  // Decimal split of the code: multiply by the reciprocal of ten (exact for 7-bit codes).
  assign code_mul      = {8'd0, in_fault_code} * 15'd205;
  assign code_tens     = code_mul[14:11];
  assign code_tens_x10 = 7'({code_tens, 3'b000} + {code_tens, 1'b0});
  assign code_ones     = 4'(in_fault_code - code_tens_x10);

  assign mel_sel = 3'(mel_idx_r);

  // Next state for one status word.
  always_comb begin
    time_now_nxt       = time_now_r;
    mel_deadline_nxt   = mel_deadline_r;
    pulse_deadline_nxt = pulse_deadline_r;
    idle_phase_nxt     = idle_phase_r;
    idle_div_nxt       = idle_div_r;
    mel_idx_nxt        = mel_idx_r;
    mel_done_nxt       = mel_done_r;
    ann_valid_nxt      = ann_valid_r;
    ann_code_nxt       = ann_code_r;
    tens_nxt           = tens_r;
    ones_nxt           = ones_r;
    group_nxt          = group_r;
    pulses_left_nxt    = pulses_left_r;
    stage_nxt          = stage_r;
    pulse_on_nxt       = pulse_on_r;
    led_nxt            = led_r;
    tone_act_nxt       = tone_act_r;
    tone_hz_nxt        = tone_hz_r;

    if (in_fire) begin
      // A fault ends the boot melody for good.
      if (in_fault_active && !mel_done_r) begin
        tone_act_nxt = 1'b0;
        mel_done_nxt = 1'b1;
      end

      if (in_fault_active) begin
        if (!ann_valid_r || in_fault_code != ann_code_r) begin
          // New code: restart the pattern with the first pulse on.
          ann_valid_nxt      = 1'b1;
          ann_code_nxt       = in_fault_code;
          tens_nxt           = code_tens;
          ones_nxt           = code_ones;
          group_nxt          = (code_tens == 4'd0);
          pulses_left_nxt    = fbci_pkg::digit_pulses((code_tens == 4'd0) ? code_ones
                                                                          : code_tens);
          stage_nxt          = fbci_pkg::STG_PULSING;
          pulse_on_nxt       = 1'b1;
          led_nxt            = 1'b1;
          tone_act_nxt       = 1'b1;
          tone_hz_nxt        = (code_tens == 4'd0) ? ones_tone_r : tens_tone_r;
          pulse_deadline_nxt = time_now_r + 32'(pulse_ms_r);
        end else if (fbci_pkg::reached(time_now_r, pulse_deadline_r)) begin
          case (stage_r)
            fbci_pkg::STG_PULSING: begin
              if (pulse_on_r) begin
                // End of a pulse: go dark, then gap or next pulse.
                led_nxt         = 1'b0;
                tone_act_nxt    = 1'b0;
                pulse_on_nxt    = 1'b0;
                pulses_left_nxt = (pulses_left_r != 4'd0) ? pulses_left_r - 4'd1 : 4'd0;
                if (pulses_left_nxt == 4'd0) begin
                  if (!group_r) begin
                    stage_nxt          = fbci_pkg::STG_GROUP_GAP;
                    pulse_deadline_nxt = time_now_r + 32'(group_gap_r);
                  end else begin
                    stage_nxt          = fbci_pkg::STG_REPEAT_GAP;
                    pulse_deadline_nxt = time_now_r + 32'(repeat_gap_r);
                  end
                end else begin
                  pulse_deadline_nxt = time_now_r + 32'(pulse_ms_r);
                end
              end else begin
                led_nxt            = 1'b1;
                pulse_on_nxt       = 1'b1;
                tone_act_nxt       = 1'b1;
                tone_hz_nxt        = group_r ? ones_tone_r : tens_tone_r;
                pulse_deadline_nxt = time_now_r + 32'(pulse_ms_r);
              end
            end
            fbci_pkg::STG_GROUP_GAP: begin
              // Move on to the ones digit.
              group_nxt          = 1'b1;
              pulses_left_nxt    = fbci_pkg::digit_pulses(ones_r);
              stage_nxt          = fbci_pkg::STG_PULSING;
              pulse_on_nxt       = 1'b1;
              led_nxt            = 1'b1;
              tone_act_nxt       = 1'b1;
              tone_hz_nxt        = ones_tone_r;
              pulse_deadline_nxt = time_now_r + 32'(pulse_ms_r);
            end
            default: begin
              // Repeat gap over, or idle: start the code from the top.
              group_nxt          = (tens_r == 4'd0);
              pulses_left_nxt    = fbci_pkg::digit_pulses((tens_r == 4'd0) ? ones_r : tens_r);
              stage_nxt          = fbci_pkg::STG_PULSING;
              pulse_on_nxt       = 1'b1;
              led_nxt            = 1'b1;
              tone_act_nxt       = 1'b1;
              tone_hz_nxt        = (tens_r == 4'd0) ? ones_tone_r : tens_tone_r;
              pulse_deadline_nxt = time_now_r + 32'(pulse_ms_r);
            end
          endcase
        end
      end else begin
        // No fault: drop any pattern in progress.
        if (ann_valid_r || pulse_on_r) begin
          tone_act_nxt = 1'b0;
          pulse_on_nxt = 1'b0;
        end
        ann_valid_nxt = 1'b0;
        stage_nxt     = fbci_pkg::STG_IDLE;

        // Idle LED pattern, one phase every ten words.
        if (idle_div_r == 4'd9) begin
          idle_div_nxt = 4'd0;
          if (detecting) begin
            led_nxt = (idle_phase_r == 4'd0) || (idle_phase_r == 4'd2);
          end else if (running) begin
            led_nxt = (idle_phase_r < 4'd2) || (idle_phase_r inside {[4'd5:4'd6]});
          end else begin
            led_nxt = (idle_phase_r < 4'd5);
          end
          idle_phase_nxt = (idle_phase_r >= 4'd9) ? 4'd0 : idle_phase_r + 4'd1;
        end else begin
          idle_div_nxt = idle_div_r + 4'd1;
        end

        // Boot melody.
        if (!mel_done_r && fbci_pkg::reached(time_now_r, mel_deadline_r)) begin
          if (32'(mel_idx_r) >= 32'(fbci_pkg::MELODY_NOTES) || 32'(mel_idx_r) >= 32'd8) begin
            tone_act_nxt = 1'b0;
            mel_done_nxt = 1'b1;
          end else begin
            mel_idx_nxt = mel_idx_r + {{(fbci_pkg::MEL_IDX_W-1){1'b0}}, 1'b1};
            if (fbci_pkg::melody_hz(mel_sel) == 12'd0) begin
              tone_act_nxt = 1'b0;
            end else begin
              tone_act_nxt = 1'b1;
              tone_hz_nxt  = fbci_pkg::melody_hz(mel_sel);
            end
            mel_deadline_nxt = time_now_r + 32'(fbci_pkg::melody_ms(mel_sel));
          end
        end
      end

      time_now_nxt = time_now_r + 32'(tick_period_r);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_period_r <= fbci_pkg::TICK_PERIOD_RST;
      pulse_ms_r    <= fbci_pkg::PULSE_RST;
      group_gap_r   <= fbci_pkg::GROUP_GAP_RST;
      repeat_gap_r  <= fbci_pkg::REPEAT_GAP_RST;
      tens_tone_r   <= fbci_pkg::TENS_TONE_RST;
      ones_tone_r   <= fbci_pkg::ONES_TONE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fbci_pkg::REG_TICK_PERIOD: tick_period_r <= cfg_wdata[7:0];
        fbci_pkg::REG_PULSE:       pulse_ms_r    <= cfg_wdata;
        fbci_pkg::REG_GROUP_GAP:   group_gap_r   <= cfg_wdata;
        fbci_pkg::REG_REPEAT_GAP:  repeat_gap_r  <= cfg_wdata;
        fbci_pkg::REG_TENS_TONE:   tens_tone_r   <= cfg_wdata[11:0];
        fbci_pkg::REG_ONES_TONE:   ones_tone_r   <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_now_r       <= '0;
      mel_deadline_r   <= '0;
      pulse_deadline_r <= '0;
      idle_phase_r     <= '0;
      idle_div_r       <= '0;
      mel_idx_r        <= '0;
      mel_done_r       <= 1'b0;
      ann_valid_r      <= 1'b0;
      ann_code_r       <= '0;
      tens_r           <= '0;
      ones_r           <= '0;
      group_r          <= 1'b0;
      pulses_left_r    <= '0;
      stage_r          <= fbci_pkg::STG_IDLE;
      pulse_on_r       <= 1'b0;
      led_r            <= 1'b0;
      tone_act_r       <= 1'b0;
      tone_hz_r        <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      time_now_r       <= time_now_nxt;
      mel_deadline_r   <= mel_deadline_nxt;
      pulse_deadline_r <= pulse_deadline_nxt;
      idle_phase_r     <= idle_phase_nxt;
      idle_div_r       <= idle_div_nxt;
      mel_idx_r        <= mel_idx_nxt;
      mel_done_r       <= mel_done_nxt;
      ann_valid_r      <= ann_valid_nxt;
      ann_code_r       <= ann_code_nxt;
      tens_r           <= tens_nxt;
      ones_r           <= ones_nxt;
      group_r          <= group_nxt;
      pulses_left_r    <= pulses_left_nxt;
      stage_r          <= stage_nxt;
      pulse_on_r       <= pulse_on_nxt;
      led_r            <= led_nxt;
      tone_act_r       <= tone_act_nxt;
      tone_hz_r        <= tone_hz_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
